@@ sv/itrd_pkg.sv @@
// Shared types and constants for the integer to radix digit string converter.
// Used by the controller, the datapath, the top level and the checker.
package itrd_pkg;

  localparam int SYM_W       = 8;   // one character byte
  localparam int NUM_SYMBOLS = 16;  // symbols held by the two alphabet registers
  localparam int CFG_W       = 64;  // widest configuration register
  localparam int CFG_IDX_W   = 2;
  localparam int RADIX_REG_W = 5;
  localparam int DIV_STEP    = 8;   // quotient bits produced per divider cycle

  localparam logic [SYM_W-1:0]       CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]       CHAR_MINUS = 8'h2D;
  localparam logic [RADIX_REG_W-1:0] MIN_RADIX  = 5'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the sign and magnitude of the input transaction
    logic start;       // clear the digit stack and remainder
    logic step;        // one divider cycle
    logic push;        // store the finished remainder as a digit
    logic emit_sign;   // load '-' into the output register
    logic rd;          // read the top of the digit stack
    logic emit_digit;  // load the looked-up symbol into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alpha_ok;    // alphabet and radix form a usable set
    logic q_zero_nxt;  // quotient after this divider cycle is zero
    logic neg;         // current value is negative
    logic out_free;    // output register can take a new byte
    logic stack_empty; // the byte being emitted is the last digit
  } dp_stat_t;

endpackage

@@ sv/itrd_ctrl.sv @@
// Controller state machine of the radix converter: sequences division,
// digit stacking and emission. Depends on itrd_pkg.
module itrd_ctrl #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itrd_pkg::dp_stat_t stat,
  output itrd_pkg::ctrl_cmd_t cmd
);
  import itrd_pkg::*;

  localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [CHK_W-1:0] CHUNK_LAST = CHK_W'(NCHUNK - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_SIGN, S_READ, S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CHK_W-1:0] chunk_r, chunk_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        // An unusable alphabet drops the transaction without output.
        if (stat.alpha_ok) begin
          cmd.start = 1'b1;
          chunk_nxt = '0;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (chunk_r == CHUNK_LAST) begin
          cmd.push  = 1'b1;
          chunk_nxt = '0;
          if (stat.q_zero_nxt) begin
            state_nxt = stat.neg ? S_SIGN : S_READ;
          end
        end else begin
          chunk_nxt = chunk_r + CHK_W'(1);
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = stat.stack_empty ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule

@@ sv/itrd_dp.sv @@
// Datapath of the radix converter: configuration registers, alphabet check,
// chunked long divider, digit stack memory and output register. Uses itrd_pkg.
module itrd_dp #(
  parameter int MAX_RADIX   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]          cfg_data,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [itrd_pkg::SYM_W-1:0]          out_symbol,
  output logic                                out_last,
  input  itrd_pkg::ctrl_cmd_t                 cmd,
  output itrd_pkg::dp_stat_t                  stat
);
  import itrd_pkg::*;

  localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int MAG_W  = NCHUNK * DIV_STEP;
  localparam int DIG_W  = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int TR_W   = DIG_W + 1;
  localparam int DEPTH  = VALUE_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [CFG_W-1:0]       alpha_lo_r, alpha_hi_r;
  logic [RADIX_REG_W-1:0] radix_r;
  logic [2*CFG_W-1:0]     alphabet;

  logic                   neg_r;
  logic [MAG_W-1:0]       q_r, q_nxt;
  logic [DIG_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIG_W-1:0]       stack_mem [DEPTH];
  logic [DIG_W-1:0]       rd_data_r;

  logic                   out_valid_r;
  logic [SYM_W-1:0]       out_symbol_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH-1:0] val_u, mag;
  logic [TR_W-1:0]        divisor;
  logic                   alpha_ok;
  logic [SYM_W-1:0]       digit_sym;

  assign alphabet = {alpha_hi_r, alpha_lo_r};
  assign divisor  = radix_r[TR_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
      radix_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALPHA_LO: alpha_lo_r <= cfg_data;
        CFG_ALPHA_HI: alpha_hi_r <= cfg_data;
        CFG_RADIX:    radix_r    <= cfg_data[RADIX_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Alphabet check: the radix range, signs and every pair of used symbols, in parallel.
  always_comb begin
    alpha_ok = (radix_r >= MIN_RADIX) && (radix_r <= RADIX_REG_W'(MAX_RADIX));
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (RADIX_REG_W'(i) < radix_r) begin
        if (alphabet[SYM_W*i +: SYM_W] == CHAR_PLUS ||
            alphabet[SYM_W*i +: SYM_W] == CHAR_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
          if (RADIX_REG_W'(j) < radix_r &&
              alphabet[SYM_W*j +: SYM_W] == alphabet[SYM_W*i +: SYM_W]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Magnitude of the input; the most negative value maps to 2^(W-1) exactly.
  assign val_u = in_value;
  assign mag   = val_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - val_u) : val_u;

  // One divider cycle: DIV_STEP restoring steps, quotient bits shifted in at
  // the bottom of the same register so that after the last chunk it holds the
  // full quotient.
  always_comb begin
    logic [TR_W-1:0] trial;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial = {rem_nxt, q_nxt[MAG_W-1]};
      q_nxt = {q_nxt[MAG_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_nxt  = DIG_W'(trial - divisor);
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DIG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= val_u[VALUE_WIDTH-1];
      q_r   <= MAG_W'(mag);
    end else if (cmd.step) begin
      q_r <= q_nxt;
    end
    if (cmd.start) begin
      rem_r <= '0;
    end else if (cmd.step) begin
      rem_r <= cmd.push ? '0 : rem_nxt;
    end
  end

  // Digit count is control state of the stack.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= '0;
    end else if (cmd.push) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.rd) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Digit stack: least significant digit is pushed first, popped last.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[cnt_r[AW-1:0]] <= rem_nxt;
    end
    if (cmd.rd) begin
      rd_data_r <= stack_mem[AW'(cnt_r - CNT_W'(1))];
    end
  end

  assign digit_sym = alphabet[SYM_W*4'(rd_data_r) +: SYM_W];

  // Output register; a new byte may be loaded while the old one is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_symbol_r <= CHAR_MINUS;
      out_last_r   <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_symbol_r <= digit_sym;
      out_last_r   <= (cnt_r == '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  assign stat.alpha_ok    = alpha_ok;
  assign stat.q_zero_nxt  = (q_nxt == '0);
  assign stat.neg         = neg_r;
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.stack_empty = (cnt_r == '0);

endmodule

@@ sv/integer_to_radix_digits_top.sv @@
// Signed integer to radix digit string converter, one transaction at a time.
// Each digit comes from the chunked long divider, DIV_STEP quotient bits per chunk,
// and is pushed on the digit stack; once the quotient is zero, the '-' for a negative
// value and then the digits, read back from the registered stack, go out as bytes.
// Synchronous active-low reset clears the configuration, the controller and out_valid.
module integer_to_radix_digits_top #(
  parameter int MAX_RADIX   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [VALUE_WIDTH-1:0]   in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itrd_pkg::SYM_W-1:0]      out_symbol,
  output logic                            out_last
);
  import itrd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  itrd_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itrd_dp #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

@@ sv/itrd_checker.sv @@
// Port-level checks on the radix converter, bound to the top level.
// Depends on itrd_pkg.
module itrd_port_checks (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [itrd_pkg::SYM_W-1:0] out_symbol,
  input logic                       out_last
);
  import itrd_pkg::*;

  // A stalled output transaction holds its byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("output changed while stalled");

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // The sign byte always precedes a digit, so it never closes a string.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_symbol != CHAR_MINUS)
    else $error("sign byte marked as last");

  // Reset leaves no output pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_radix_digits_top itrd_port_checks u_itrd_port_checks (.*);

@@ tb/itrd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the integer to radix digit converter: follows configuration
// writes and both channels, predicts each character string and compares.
// Depends on itrd_pkg for widths, register indexes and character codes.
module itrd_checker #(
  parameter int MAX_RADIX   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itrd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [VALUE_WIDTH-1:0]     in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [itrd_pkg::SYM_W-1:0]        out_symbol,
  input  logic                              out_last,
  output int                                fail_count,
  output int                                chars_pending,
  output int                                chars_checked
);
  import itrd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } char_t;

  char_t                  expected_chars[$];
  logic [CFG_W-1:0]       alpha_lo;
  logic [CFG_W-1:0]       alpha_hi;
  logic [RADIX_REG_W-1:0] radix;

  function automatic logic [SYM_W-1:0] symbol_of(input int unsigned k);
    logic [CFG_W-1:0] word;
    word = (k < 8) ? alpha_lo : alpha_hi;
    return word[(k % 8) * SYM_W +: SYM_W];
  endfunction

  // Only the symbols below the radix matter; the rest may hold anything.
  function automatic bit alphabet_usable();
    if (radix < MIN_RADIX || radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      if (symbol_of(i) == CHAR_PLUS || symbol_of(i) == CHAR_MINUS) return 1'b0;
      for (int j = i + 1; j < radix; j++)
        if (symbol_of(j) == symbol_of(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_string(input logic [VALUE_WIDTH-1:0] value);
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    int unsigned            digits[$];
    char_t                  ch;
    if (!alphabet_usable()) return;
    neg = value[VALUE_WIDTH-1];
    // The most negative value wraps to its own magnitude as an unsigned number.
    mag = neg ? (~value + 1'b1) : value;
    do begin
      digits.push_back(mag % radix);
      mag = mag / radix;
    end while (mag != 0);
    if (neg) begin
      ch.symbol = CHAR_MINUS;
      ch.last   = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      ch.symbol = symbol_of(digits[k]);
      ch.last   = (k == 0);
      expected_chars.push_back(ch);
    end
  endtask

  always @(posedge clk) begin
    char_t want;
    if (!rst_n) begin
      alpha_lo      = '0;
      alpha_hi      = '0;
      radix         = '0;
      fail_count    = 0;
      chars_checked = 0;
      expected_chars.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALPHA_LO: alpha_lo = cfg_data;
          CFG_ALPHA_HI: alpha_hi = cfg_data;
          CFG_RADIX: radix = cfg_data[RADIX_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_string(in_value);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("symbol: no character expected, got 8'h%02h (last %b)", out_symbol, out_last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("symbol: expected 8'h%02h, got 8'h%02h", want.symbol, out_symbol);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_count++;
          end
          chars_checked++;
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

@@ tb/integer_to_radix_digits_top_test.sv @@
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, alphabet settings, integer
// stimulus and output back-pressure. Depends on itrd_pkg, itrd_checker and the block.
module integer_to_radix_digits_top_test;
  import itrd_pkg::*;

  localparam int MAX_RADIX   = 16;
  localparam int VALUE_WIDTH = 32;

  // "01234567" and "89ABCDEF", symbol 0 in the lowest byte.
  localparam logic [CFG_W-1:0] HEX_LO = 64'h3736353433323130;
  localparam logic [CFG_W-1:0] HEX_HI = 64'h4645444342413938;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_BUSY} rx_pattern_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [SYM_W-1:0]              out_symbol;
  logic                          out_last;

  int fail_count;
  int chars_pending;
  int chars_checked;

  int          items_sent = 0;
  int          settings_loaded = 0;
  int          burst_left = 0;
  logic        long_stall_req = 1'b0;
  logic        long_stall_done = 1'b0;
  rx_pattern_t rx_pattern = RX_STREAM;
  int          rx_left = 0;

  integer_to_radix_digits_top #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_symbol(out_symbol),
    .out_last  (out_last)
  );

  itrd_checker #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .chars_pending(chars_pending),
    .chars_checked(chars_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: changing stall patterns, plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_stall_req && !long_stall_done) begin
      long_stall_done = 1'b1;
      out_ready <= 1'b0;
      repeat (400) @(negedge clk);
    end else begin
      if (rx_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        rx_left    = $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_pattern)
        RX_STREAM: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // All driving tasks start and finish at a falling edge.
  task automatic push_value(input logic [VALUE_WIDTH-1:0] value);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 180) : $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap_len) @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // An item under an unusable alphabet leaves nothing pending, so the pause
  // covers the worst-case conversion time as well.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic load_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                               input logic [RADIX_REG_W-1:0] rdx);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALPHA_LO;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= CFG_ALPHA_HI;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= CFG_RADIX;
    cfg_data  <= CFG_W'(rdx);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [VALUE_WIDTH-1:0] next_operand();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 40);
      3:       return -$urandom_range(1, 40);
      4:       return {1'b1, 31'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0]       lo;
    logic [CFG_W-1:0]       hi;
    logic [RADIX_REG_W-1:0] rdx;
    int                     start;
    int                     stride;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The reset configuration has radix zero, so these give no characters.
    push_value(32'd0);
    push_value(32'hFFFF_FFFF);

    load_alphabet(HEX_LO, HEX_HI, 5'd10);
    push_value(32'd0);
    push_value(32'd10);
    push_value(-32'sd10);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_value(32'd123456789);
    push_value(-32'sd7);

    // Binary: the most negative value gives the longest string.
    load_alphabet(HEX_LO, HEX_HI, 5'd2);
    push_value(32'h8000_0000);
    push_value(32'h7FFF_FFFF);
    push_value(32'd2);
    push_value(32'd1);

    load_alphabet(HEX_LO, HEX_HI, 5'd16);
    push_value(32'hFFFF_FFFF);
    push_value(32'd16);
    push_value(32'd255);

    // A zero byte is an ordinary symbol; '-' beyond the radix is not looked at.
    load_alphabet(64'h2D2D2D2D2D7EFF00, 64'h2B2B2B2B2B2B2B2B, 5'd3);
    push_value(32'd3);
    push_value(-32'sd5);
    push_value(32'd9);

    // Unusable alphabets: radix out of range, a sign character, a repeat.
    load_alphabet(HEX_LO, HEX_HI, 5'd1);
    push_value(32'd5);
    load_alphabet(HEX_LO, HEX_HI, 5'd17);
    push_value(32'd5);
    load_alphabet(HEX_LO, HEX_HI, 5'd31);
    push_value(-32'sd5);
    load_alphabet(HEX_LO, 64'h2B45444342413938, 5'd16);
    push_value(32'd5);
    load_alphabet(64'h373635343332312D, HEX_HI, 5'd2);
    push_value(32'd5);
    load_alphabet(64'h3736353033323130, HEX_HI, 5'd5);
    push_value(32'd5);

    for (int p = 0; p < 8; p++) begin
      start  = $urandom_range(0, 255);
      stride = $urandom_range(0, 127) * 2 + 1;
      // An odd stride keeps all sixteen symbols distinct.
      for (int k = 0; k < 16; k++) begin
        if (k < 8) lo[8*k +: 8] = 8'(start + k * stride);
        else hi[8*(k-8) +: 8] = 8'(start + k * stride);
      end
      rdx = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(2, 16));
      if ($urandom_range(0, 7) == 0) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      if (p == 1) begin
        lo  = HEX_LO;
        hi  = HEX_HI;
        rdx = 5'd10;
      end
      load_alphabet(lo, hi, rdx);
      // The receiver holds off while the sender keeps offering transactions.
      if (p == 1) long_stall_req <= 1'b1;
      repeat (11) push_value(next_operand());
    end

    drain_results();
    $display("Converted %0d integers under %0d alphabet settings, %0d characters compared.",
             items_sent, settings_loaded, chars_checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
